### rtl/bcpc_pkg.sv
// Package: shared constants, codes and controller/datapath types for the breath cycle sequencer.
package bcpc_pkg;

  // Default field widths
  localparam int TIME_BITS_DEF     = 14;
  localparam int PRESSURE_BITS_DEF = 12;

  // Configuration register widths and indexes
  localparam int RATE_W  = 6;
  localparam int PEEP_W  = 9;
  localparam int PLAT_W  = 10;
  localparam int PEAK_W  = 10;
  localparam int CFG_W   = 10;
  localparam int CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RATE = 2'd0,
    CFG_PEEP = 2'd1,
    CFG_PLAT = 2'd2,
    CFG_PEAK = 2'd3
  } cfg_idx_e;

  // Register reset values
  localparam logic [RATE_W-1:0] RST_RATE = RATE_W'(20);
  localparam logic [PEEP_W-1:0] RST_PEEP = PEEP_W'(50);
  localparam logic [PLAT_W-1:0] RST_PLAT = PLAT_W'(300);
  localparam logic [PEAK_W-1:0] RST_PEAK = PEAK_W'(600);

  // Inhalation time = (6000 / rate) / 3 = 2000 / rate, by restoring division
  localparam int INH_W     = 11;
  localparam int DIV_STEPS = INH_W;
  localparam logic [INH_W-1:0] DIV_DIVIDEND = INH_W'(2000);

  // 80 percent mark = floor(4 * inh / 5) = (inh * 52432) >> 16, exact for inh <= 2000
  localparam int RECIP_W     = 16;
  localparam int RECIP_SHIFT = 16;
  localparam int PROD_W      = INH_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP_4_5 = RECIP_W'(52432);

  // Reset timing for the reset rate of 20
  localparam logic [INH_W-1:0] RST_INHALE = INH_W'(100);
  localparam logic [INH_W-1:0] RST_THRESH = INH_W'(80);

  // Safeguard margins (mm H2O) and debounce times (centiseconds)
  localparam int PEAK_TRIG_MARGIN = 30;
  localparam int PEAK_HIGH_MARGIN = 10;
  localparam int PEEP_HOLD_MARGIN = 20;
  localparam int DEB_W            = 4;
  localparam logic [DEB_W-1:0] PEAK_DEBOUNCE    = DEB_W'(5);
  localparam logic [DEB_W-1:0] RELEASE_DEBOUNCE = DEB_W'(3);
  localparam logic [DEB_W-1:0] HOLD_DEBOUNCE    = DEB_W'(10);

  typedef enum logic {
    PH_INHALE = 1'b0,
    PH_EXHALE = 1'b1
  } phase_e;

  typedef enum logic [1:0] {
    SP_INSPI       = 2'd0,
    SP_HOLD_INSPI  = 2'd1,
    SP_EXHALE      = 2'd2,
    SP_HOLD_EXHALE = 2'd3
  } sub_e;

  typedef enum logic [1:0] {
    BL_NONE   = 2'd0,
    BL_CLOSE  = 2'd1,
    BL_OPEN   = 2'd2,
    BL_MIDDLE = 2'd3
  } blower_e;

  typedef enum logic [1:0] {
    PV_NONE  = 2'd0,
    PV_CLOSE = 2'd1,
    PV_OPEN  = 2'd2
  } patient_e;

  // Controller -> datapath commands
  typedef struct packed {
    logic capture;   // latch the accepted word
    logic div_step;  // one restoring-division step
    logic scale;     // register the 80 percent product
    logic commit;    // update state and load the output word
  } cmd_t;

  // Datapath -> controller status
  typedef struct packed {
    logic out_busy;  // output word held and not taken this cycle
  } sts_t;

endpackage

### rtl/breath_cycle_phase_controller.sv
// Top level: breath cycle sequencer with stream ports and a register write port.
//
//  channel  | signals                        | word contents
//  ---------+--------------------------------+---------------------------------------
//  in       | s_axis_tvalid/tready/tdata/tuser | tuser = start of cycle, tdata = request
//  out      | m_axis_tvalid/tready/tdata     | one result word per accepted word
//  config   | cfg_we_i/cfg_idx_i/cfg_data_i  | rate, min PEEP, max plateau, max peak
//
// A tick word goes from capture straight to commit; a cycle-start word first runs
// 11 restoring-division steps for 2000 / rate and one 80 percent multiply before commit.
// The input opens again in the idle cycle after commit. A stalled output register
// holds the sequencer at commit and keeps the input closed until the word is taken.
// rst_ni clears the control, configuration and phase state to the rate-20 defaults;
// there is no clearing pass.
module breath_cycle_phase_controller #(
  parameter int TIME_BITS     = bcpc_pkg::TIME_BITS_DEF,
  parameter int PRESSURE_BITS = bcpc_pkg::PRESSURE_BITS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,

  // tdata: pressure [PRESSURE_BITS-1:0], centisec above it, zero pad to bytes
  input  logic [((PRESSURE_BITS + TIME_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata,
  // tuser: req_type (1 = start new cycle)
  input  logic                                   s_axis_tuser,
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,

  // tdata: cycle_phase, sub_phase[2], blower_action[2], blower_increase,
  //        patient_action[2], patient_increase, yellow_alarm, red_alarm,
  //        peak_value, plateau_value, peep_value, vigilance_on (lowest bit first)
  output logic [((12 + 3 * PRESSURE_BITS + 7) / 8) * 8 - 1:0] m_axis_tdata,
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,

  input  logic                                   cfg_we_i,
  input  logic [bcpc_pkg::CFG_IDX_W-1:0]         cfg_idx_i,
  input  logic [bcpc_pkg::CFG_W-1:0]             cfg_data_i
);

  localparam int OUT_RAW = 12 + 3 * PRESSURE_BITS;
  localparam int OUT_W   = ((OUT_RAW + 7) / 8) * 8;

  bcpc_pkg::cmd_t cmd;
  bcpc_pkg::sts_t sts;
  logic [OUT_RAW-1:0] out_raw;

  bcpc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_start_i (s_axis_tuser),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  bcpc_dp #(
    .TIME_BITS     (TIME_BITS),
    .PRESSURE_BITS (PRESSURE_BITS),
    .OUT_W         (OUT_RAW)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .in_start_i    (s_axis_tuser),
    .in_pressure_i (s_axis_tdata[PRESSURE_BITS-1:0]),
    .in_centisec_i (s_axis_tdata[PRESSURE_BITS+TIME_BITS-1:PRESSURE_BITS]),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_data_o    (out_raw)
  );

  // zero pad to whole bytes
  assign m_axis_tdata = OUT_W'(out_raw);

endmodule

### rtl/bcpc_ctrl.sv
// Sequencer: capture, division and scaling (cycle-start words only), then commit.
module bcpc_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           in_start_i,
  output logic           in_ready_o,
  input  bcpc_pkg::sts_t sts_i,
  output bcpc_pkg::cmd_t cmd_o
);

  localparam int CNT_W = $clog2(bcpc_pkg::DIV_STEPS);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_SCALE,
    S_EMIT
  } state_e;

  state_e             state_q;
  logic [CNT_W-1:0]   cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          cnt_q <= '0;
          if (in_valid_i) begin
            state_q <= in_start_i ? S_DIV : S_EMIT;
          end
        end
        S_DIV: begin
          cnt_q <= cnt_q + CNT_W'(1);
          if (cnt_q == CNT_W'(bcpc_pkg::DIV_STEPS - 1)) begin
            state_q <= S_SCALE;
          end
        end
        S_SCALE: state_q <= S_EMIT;
        S_EMIT: begin
          if (!sts_i.out_busy) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    cmd_o          = '0;
    cmd_o.capture  = (state_q == S_IDLE) && in_valid_i;
    cmd_o.div_step = (state_q == S_DIV);
    cmd_o.scale    = (state_q == S_SCALE);
    cmd_o.commit   = (state_q == S_EMIT) && !sts_i.out_busy;
  end

endmodule

### rtl/bcpc_dp.sv
// Datapath: config registers, divider, phase state, safeguards and output register.
module bcpc_dp #(
  parameter int TIME_BITS     = bcpc_pkg::TIME_BITS_DEF,
  parameter int PRESSURE_BITS = bcpc_pkg::PRESSURE_BITS_DEF,
  parameter int OUT_W         = 48
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [bcpc_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [bcpc_pkg::CFG_W-1:0]    cfg_data_i,
  input  logic                          in_start_i,
  input  logic signed [PRESSURE_BITS-1:0] in_pressure_i,
  input  logic [TIME_BITS-1:0]          in_centisec_i,
  input  bcpc_pkg::cmd_t                cmd_i,
  output bcpc_pkg::sts_t                sts_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [OUT_W-1:0]              out_data_o
);

  localparam int PW  = PRESSURE_BITS;
  localparam int TW  = TIME_BITS;
  localparam int TW1 = TW + 1;
  localparam int CW  = ((PW > 11) ? PW : 11) + 2;
  localparam int RW  = bcpc_pkg::RATE_W;
  localparam int IW  = bcpc_pkg::INH_W;

  localparam logic signed [CW-1:0] K_PK_TRIG = CW'(bcpc_pkg::PEAK_TRIG_MARGIN);
  localparam logic signed [CW-1:0] K_PK_HIGH = CW'(bcpc_pkg::PEAK_HIGH_MARGIN);
  localparam logic signed [CW-1:0] K_PEEP_HD = CW'(bcpc_pkg::PEEP_HOLD_MARGIN);

  // stamp slots
  localparam int ST_PK_TRG = 0;
  localparam int ST_PK_REL = 1;
  localparam int ST_PL_TRG = 2;
  localparam int ST_PL_REL = 3;
  localparam int ST_HD_TRG = 4;
  localparam int ST_HD_REL = 5;
  localparam int NST       = 6;

  // elapsed since a stamp, compared against a debounce time as now >= stamp + k (no wrap)
  function automatic logic el_ge(input logic [TW-1:0] now, input logic [TW-1:0] st,
                                 input logic [bcpc_pkg::DEB_W-1:0] k);
    return {1'b0, now} >= ({1'b0, st} + TW1'(k));
  endfunction

  // configuration
  logic [bcpc_pkg::RATE_W-1:0] rate_q;
  logic [bcpc_pkg::PEEP_W-1:0] peep_q;
  logic [bcpc_pkg::PLAT_W-1:0] plat_q;
  logic [bcpc_pkg::PEAK_W-1:0] peak_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q <= bcpc_pkg::RST_RATE;
      peep_q <= bcpc_pkg::RST_PEEP;
      plat_q <= bcpc_pkg::RST_PLAT;
      peak_q <= bcpc_pkg::RST_PEAK;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        bcpc_pkg::CFG_RATE: rate_q <= cfg_data_i[bcpc_pkg::RATE_W-1:0];
        bcpc_pkg::CFG_PEEP: peep_q <= cfg_data_i[bcpc_pkg::PEEP_W-1:0];
        bcpc_pkg::CFG_PLAT: plat_q <= cfg_data_i[bcpc_pkg::PLAT_W-1:0];
        bcpc_pkg::CFG_PEAK: peak_q <= cfg_data_i[bcpc_pkg::PEAK_W-1:0];
        default: ;
      endcase
    end
  end

  // captured word
  logic                  start_q;
  logic signed [PW-1:0]  p_q;
  logic [TW-1:0]         now_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= 1'b0;
    end else if (cmd_i.capture) begin
      start_q <= in_start_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      p_q   <= in_pressure_i;
      now_q <= in_centisec_i;
    end
  end

  // restoring divider: 2000 / rate, one quotient bit a cycle
  logic [RW-1:0]                  dvs_q;
  logic [RW-1:0]                  rem_q;
  logic [IW-1:0]                  quo_q;
  logic [IW-1:0]                  dvd_q;
  logic [RW:0]                    rem_sh;
  logic                           rem_ge;
  logic [bcpc_pkg::PROD_W-1:0]    prod_q;

  assign rem_sh = {rem_q, dvd_q[IW-1]};
  assign rem_ge = rem_sh >= {1'b0, dvs_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      dvs_q <= (rate_q == '0) ? RW'(1) : rate_q;
      rem_q <= '0;
      quo_q <= '0;
      dvd_q <= bcpc_pkg::DIV_DIVIDEND;
    end else if (cmd_i.div_step) begin
      rem_q <= rem_ge ? RW'(rem_sh - {1'b0, dvs_q}) : rem_sh[RW-1:0];
      quo_q <= {quo_q[IW-2:0], rem_ge};
      dvd_q <= {dvd_q[IW-2:0], 1'b0};
    end
    if (cmd_i.scale) begin
      prod_q <= bcpc_pkg::PROD_W'(quo_q) * bcpc_pkg::PROD_W'(bcpc_pkg::RECIP_4_5);
    end
  end

  // sequencing state
  bcpc_pkg::phase_e     phase_q, phase_n;
  bcpc_pkg::sub_e       sub_q, sub_n;
  bcpc_pkg::blower_e    blw_q, blw_n;
  bcpc_pkg::patient_e   pat_q, pat_n;
  logic                 vig_q, vig_n;
  logic [IW-1:0]        inh_q, inh_n;
  logic [IW-1:0]        thr_q, thr_n;
  logic [TW-1:0]        st_q [NST];
  logic [TW-1:0]        st_n [NST];
  logic [NST-1:0]       arm_q, arm_n;
  logic signed [PW-1:0] cap_q [3];
  logic signed [PW-1:0] cap_n [3];
  logic                 b_inc, p_inc, yellow, red;

  logic signed [CW-1:0] p_s, peak_s, plat_s, peep_s;
  logic                 ge_pk_trig, ge_peak, ge_pk_high, ge_plat, le_peep_hd, le_peep;

  assign p_s    = {{(CW-PW){p_q[PW-1]}}, p_q};
  assign peak_s = {{(CW-bcpc_pkg::PEAK_W){1'b0}}, peak_q};
  assign plat_s = {{(CW-bcpc_pkg::PLAT_W){1'b0}}, plat_q};
  assign peep_s = {{(CW-bcpc_pkg::PEEP_W){1'b0}}, peep_q};

  assign ge_pk_trig = p_s >= (peak_s - K_PK_TRIG);
  assign ge_peak    = p_s >= peak_s;
  assign ge_pk_high = p_s >= (peak_s + K_PK_HIGH);
  assign ge_plat    = p_s >= plat_s;
  assign le_peep_hd = p_s <= (peep_s + K_PEEP_HD);
  assign le_peep    = p_s <= peep_s;

  always_comb begin
    phase_n = phase_q;
    sub_n   = sub_q;
    blw_n   = blw_q;
    pat_n   = pat_q;
    vig_n   = vig_q;
    inh_n   = inh_q;
    thr_n   = thr_q;
    st_n    = st_q;
    arm_n   = arm_q;
    cap_n   = cap_q;
    b_inc   = 1'b0;
    p_inc   = 1'b0;
    yellow  = 1'b0;
    red     = 1'b0;

    if (start_q) begin
      // new cycle: latch timing, restart in inspiration, drop the hold debounce
      phase_n = bcpc_pkg::PH_INHALE;
      sub_n   = bcpc_pkg::SP_INSPI;
      vig_n   = 1'b0;
      inh_n   = quo_q;
      thr_n   = prod_q[bcpc_pkg::PROD_W-1:bcpc_pkg::RECIP_SHIFT];
      st_n[ST_HD_TRG]  = '0;
      st_n[ST_HD_REL]  = '0;
      arm_n[ST_HD_TRG] = 1'b0;
      arm_n[ST_HD_REL] = 1'b0;
    end else begin
      // subphase selection
      if (now_q < TW'(inh_q)) begin
        phase_n = bcpc_pkg::PH_INHALE;
        if (now_q < TW'(thr_q)) begin
          if (sub_n != bcpc_pkg::SP_HOLD_INSPI) begin
            sub_n = bcpc_pkg::SP_INSPI;
            vig_n = 1'b0;
          end
        end else begin
          sub_n = bcpc_pkg::SP_HOLD_INSPI;
          vig_n = 1'b0;
        end
      end else begin
        phase_n = bcpc_pkg::PH_EXHALE;
        if (sub_n != bcpc_pkg::SP_HOLD_EXHALE) begin
          sub_n = bcpc_pkg::SP_EXHALE;
          vig_n = 1'b0;
        end
      end

      // subphase actions, skipped while in peak vigilance
      if (!vig_n) begin
        case (sub_n)
          bcpc_pkg::SP_INSPI: begin
            blw_n    = bcpc_pkg::BL_OPEN;
            pat_n    = bcpc_pkg::PV_CLOSE;
            cap_n[0] = p_q;
          end
          bcpc_pkg::SP_HOLD_INSPI: begin
            blw_n    = bcpc_pkg::BL_CLOSE;
            pat_n    = bcpc_pkg::PV_CLOSE;
            cap_n[1] = p_q;
          end
          bcpc_pkg::SP_EXHALE: begin
            blw_n    = bcpc_pkg::BL_CLOSE;
            pat_n    = bcpc_pkg::PV_OPEN;
            cap_n[2] = p_q;
          end
          default: begin
            blw_n = bcpc_pkg::BL_CLOSE;
            pat_n = bcpc_pkg::PV_CLOSE;
          end
        endcase
      end

      // peak safeguard
      if (sub_n == bcpc_pkg::SP_INSPI) begin
        if (ge_pk_trig) begin
          if (!arm_n[ST_PK_TRG]) begin
            st_n[ST_PK_TRG]  = now_q;
            arm_n[ST_PK_TRG] = 1'b1;
          end
          if (el_ge(now_q, st_n[ST_PK_TRG], bcpc_pkg::PEAK_DEBOUNCE)) begin
            blw_n = bcpc_pkg::BL_MIDDLE;
            vig_n = 1'b1;
          end
        end else if (arm_n[ST_PK_TRG]) begin
          if (!arm_n[ST_PK_REL]) begin
            st_n[ST_PK_REL]  = now_q;
            arm_n[ST_PK_REL] = 1'b1;
          end
          if (el_ge(now_q, st_n[ST_PK_REL], bcpc_pkg::RELEASE_DEBOUNCE)) begin
            st_n[ST_PK_TRG]  = '0;
            st_n[ST_PK_REL]  = '0;
            arm_n[ST_PK_TRG] = 1'b0;
            arm_n[ST_PK_REL] = 1'b0;
          end
        end
        if (ge_peak) begin
          sub_n    = bcpc_pkg::SP_HOLD_INSPI;
          vig_n    = 1'b0;
          yellow   = 1'b1;
          blw_n    = bcpc_pkg::BL_CLOSE;
          pat_n    = bcpc_pkg::PV_CLOSE;
          cap_n[1] = p_q;
        end
      end
      if (ge_pk_high) begin
        p_inc  = 1'b1;
        yellow = 1'b1;
      end

      // plateau safeguard
      if (sub_n == bcpc_pkg::SP_HOLD_INSPI) begin
        if (ge_plat) begin
          if (!arm_n[ST_PL_TRG]) begin
            st_n[ST_PL_TRG]  = now_q;
            arm_n[ST_PL_TRG] = 1'b1;
          end
        end else if (arm_n[ST_PL_TRG]) begin
          if (!arm_n[ST_PL_REL]) begin
            st_n[ST_PL_REL]  = now_q;
            arm_n[ST_PL_REL] = 1'b1;
          end
          if (el_ge(now_q, st_n[ST_PL_REL], bcpc_pkg::RELEASE_DEBOUNCE)) begin
            st_n[ST_PL_TRG]  = '0;
            st_n[ST_PL_REL]  = '0;
            arm_n[ST_PL_TRG] = 1'b0;
            arm_n[ST_PL_REL] = 1'b0;
            blw_n    = bcpc_pkg::BL_CLOSE;
            pat_n    = bcpc_pkg::PV_CLOSE;
            cap_n[1] = p_q;
          end
        end
      end

      // expiratory hold safeguard
      if (phase_n == bcpc_pkg::PH_EXHALE) begin
        if (le_peep_hd) begin
          if (!arm_n[ST_HD_TRG]) begin
            st_n[ST_HD_TRG]  = now_q;
            arm_n[ST_HD_TRG] = 1'b1;
          end
          if (el_ge(now_q, st_n[ST_HD_TRG], bcpc_pkg::HOLD_DEBOUNCE)) begin
            sub_n = bcpc_pkg::SP_HOLD_EXHALE;
            vig_n = 1'b0;
            blw_n = bcpc_pkg::BL_CLOSE;
            pat_n = bcpc_pkg::PV_CLOSE;
          end
        end else if (arm_n[ST_HD_TRG]) begin
          if (!arm_n[ST_HD_REL]) begin
            st_n[ST_HD_REL]  = now_q;
            arm_n[ST_HD_REL] = 1'b1;
          end
          if (el_ge(now_q, st_n[ST_HD_REL], bcpc_pkg::RELEASE_DEBOUNCE)) begin
            st_n[ST_HD_TRG]  = '0;
            st_n[ST_HD_REL]  = '0;
            arm_n[ST_HD_TRG] = 1'b0;
            arm_n[ST_HD_REL] = 1'b0;
          end
        end
      end

      // PEEP maintenance
      if (le_peep) begin
        b_inc = 1'b1;
        red   = 1'b1;
      end
    end
  end

  // state update and output word
  logic             out_valid_q;
  logic [OUT_W-1:0] out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= bcpc_pkg::PH_INHALE;
      sub_q       <= bcpc_pkg::SP_INSPI;
      blw_q       <= bcpc_pkg::BL_NONE;
      pat_q       <= bcpc_pkg::PV_NONE;
      vig_q       <= 1'b0;
      inh_q       <= bcpc_pkg::RST_INHALE;
      thr_q       <= bcpc_pkg::RST_THRESH;
      arm_q       <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NST; i++) begin
        st_q[i] <= '0;
      end
      for (int i = 0; i < 3; i++) begin
        cap_q[i] <= '0;
      end
    end else begin
      if (cmd_i.commit) begin
        phase_q     <= phase_n;
        sub_q       <= sub_n;
        blw_q       <= blw_n;
        pat_q       <= pat_n;
        vig_q       <= vig_n;
        inh_q       <= inh_n;
        thr_q       <= thr_n;
        st_q        <= st_n;
        arm_q       <= arm_n;
        cap_q       <= cap_n;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_data_q <= {vig_n, cap_n[2], cap_n[1], cap_n[0], red, yellow, p_inc, pat_n,
                     b_inc, blw_n, sub_n, phase_n};
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_data_o      = out_data_q;
  assign sts_o.out_busy  = out_valid_q && !out_ready_i;

endmodule

### rtl/bcpc_chk.sv
// Port-level checker for the breath cycle sequencer, bound to the top level.
module bcpc_chk #(
  parameter int PRESSURE_BITS = bcpc_pkg::PRESSURE_BITS_DEF
) (
  input logic clk_i,
  input logic rst_ni,
  input logic s_axis_tvalid,
  input logic s_axis_tready,
  input logic [((12 + 3 * PRESSURE_BITS + 7) / 8) * 8 - 1:0] m_axis_tdata,
  input logic m_axis_tvalid,
  input logic m_axis_tready
);

  localparam int VIG_BIT = 11 + 3 * PRESSURE_BITS;

  // a held result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result word dropped while stalled");

  // one word at a time: after an accept the input side closes
  a_in_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted while a word is in flight");

  // low PEEP raises red and asks for a blower increase together
  a_red_inc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[10] == m_axis_tdata[5])
    else $error("red alarm and blower increase disagree");

  // patient valve increase only with the yellow alarm
  a_yellow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[8] |-> m_axis_tdata[9])
    else $error("patient increase without yellow alarm");

  // vigilance lives only in inspiration
  a_vig: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[VIG_BIT] |->
      m_axis_tdata[0] == bcpc_pkg::PH_INHALE && m_axis_tdata[2:1] == bcpc_pkg::SP_INSPI)
    else $error("vigilance outside inspiration");

endmodule

bind breath_cycle_phase_controller bcpc_chk #(
  .PRESSURE_BITS (PRESSURE_BITS)
) u_bcpc_chk (.*);

### dv/breath_cycle_phase_controller_tb.sv
`timescale 1ns / 1ps
// Testbench: random breath sequences against a scoreboard that predicts every result word.
module breath_cycle_phase_controller_tb;

  localparam int TB          = 14;
  localparam int PB          = 12;
  localparam int IN_W        = ((PB + TB + 7) / 8) * 8;
  localparam int OUT_W       = ((12 + 3 * PB + 7) / 8) * 8;
  // Slowest run: ~1900 words with their processing, sender gaps and receiver stalls,
  // plus two HOLD_OFF output hold-offs and the phase drains; taken several times over.
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_OFF    = 300;
  // Settling time after a drain, with slack beyond a cycle-start word's processing.
  localparam int SETTLE      = 20;

  // Result word, lowest bit first: cycle_phase up to vigilance_on.
  typedef struct packed {
    logic                 vig;
    logic signed [PB-1:0] peep_v;
    logic signed [PB-1:0] plat_v;
    logic signed [PB-1:0] peak_v;
    logic                 red;
    logic                 yellow;
    logic                 p_inc;
    bcpc_pkg::patient_e   pat;
    logic                 b_inc;
    bcpc_pkg::blower_e    blw;
    bcpc_pkg::sub_e       sub;
    bcpc_pkg::phase_e     ph;
  } result_t;

  // Breath sequencer scoreboard: tracks the sequencer state per accepted word
  // and queues the result word that word must produce.
  class breath_tracker;
    typedef enum int {PK_TRIG, PK_REL, PL_TRIG, PL_REL, HD_TRIG, HD_REL} stamp_id_e;

    logic [5:0]           rate_cfg;
    logic [8:0]           peep_cfg;
    logic [9:0]           plat_cfg;
    logic [9:0]           peak_cfg;
    bcpc_pkg::phase_e     ph;
    bcpc_pkg::sub_e       sub;
    bit                   vig;
    logic [TB-1:0]        inh;
    bcpc_pkg::blower_e    blw;
    bcpc_pkg::patient_e   pat;
    logic signed [PB-1:0] cap_peak;
    logic signed [PB-1:0] cap_plat;
    logic signed [PB-1:0] cap_peep;
    logic [TB-1:0]        stamp_at[6];
    bit                   armed[6];
    result_t              expected_words[$];
    int                   errors;

    function new();
      rate_cfg = bcpc_pkg::RST_RATE;
      peep_cfg = bcpc_pkg::RST_PEEP;
      plat_cfg = bcpc_pkg::RST_PLAT;
      peak_cfg = bcpc_pkg::RST_PEAK;
      ph       = bcpc_pkg::PH_INHALE;
      sub      = bcpc_pkg::SP_INSPI;
      vig      = 0;
      latch_rate();
      for (int i = 0; i < 6; i++) begin
        stamp_at[i] = '0;
        armed[i]    = 0;
      end
      cap_peak = '0;
      cap_plat = '0;
      cap_peep = '0;
      blw      = bcpc_pkg::BL_NONE;
      pat      = bcpc_pkg::PV_NONE;
      errors   = 0;
    endfunction

    function void set_reg(bcpc_pkg::cfg_idx_e idx, logic [bcpc_pkg::CFG_W-1:0] v);
      case (idx)
        bcpc_pkg::CFG_RATE: rate_cfg = v[5:0];
        bcpc_pkg::CFG_PEEP: peep_cfg = v[8:0];
        bcpc_pkg::CFG_PLAT: plat_cfg = v;
        bcpc_pkg::CFG_PEAK: peak_cfg = v;
        default: ;
      endcase
    endfunction

    // zero rate runs as 1 breath per minute
    function void latch_rate();
      int r;
      r = rate_cfg;
      if (r == 0) r = 1;
      inh = TB'((6000 / r) / 3);
    endfunction

    function void clear(stamp_id_e id);
      stamp_at[id] = '0;
      armed[id]    = 0;
    endfunction

    function void arm(stamp_id_e id, logic [TB-1:0] now);
      if (!armed[id]) begin
        stamp_at[id] = now;
        armed[id]    = 1;
      end
    endfunction

    // signed: a stamp left over from an earlier cycle reads as negative time
    function int since(stamp_id_e id, logic [TB-1:0] now);
      return int'(now) - int'(stamp_at[id]);
    endfunction

    function void set_sub(bcpc_pkg::sub_e s);
      sub = s;
      vig = 0;
    endfunction

    function void plateau_cmd(logic signed [PB-1:0] p);
      blw      = bcpc_pkg::BL_CLOSE;
      pat      = bcpc_pkg::PV_CLOSE;
      cap_plat = p;
    endfunction

    function void note_word(bit start, logic signed [PB-1:0] p, logic [TB-1:0] now);
      int      pv;
      int      pk;
      int      pl;
      int      pp;
      bit      b_inc;
      bit      p_inc;
      bit      yellow;
      bit      red;
      result_t r;
      pv     = p;
      pk     = peak_cfg;
      pl     = plat_cfg;
      pp     = peep_cfg;
      b_inc  = 0;
      p_inc  = 0;
      yellow = 0;
      red    = 0;
      if (start) begin
        ph = bcpc_pkg::PH_INHALE;
        set_sub(bcpc_pkg::SP_INSPI);
        latch_rate();
        clear(HD_TRIG);
        clear(HD_REL);
      end else begin
        // subphase from the time in the cycle
        if (now < inh) begin
          ph = bcpc_pkg::PH_INHALE;
          if (int'(now) < int'(inh) * 80 / 100) begin
            if (sub != bcpc_pkg::SP_HOLD_INSPI) set_sub(bcpc_pkg::SP_INSPI);
          end else begin
            set_sub(bcpc_pkg::SP_HOLD_INSPI);
          end
        end else begin
          ph = bcpc_pkg::PH_EXHALE;
          if (sub != bcpc_pkg::SP_HOLD_EXHALE) set_sub(bcpc_pkg::SP_EXHALE);
        end
        // valve commands of the subphase, skipped under peak vigilance
        if (!vig) begin
          case (sub)
            bcpc_pkg::SP_INSPI: begin
              blw      = bcpc_pkg::BL_OPEN;
              pat      = bcpc_pkg::PV_CLOSE;
              cap_peak = p;
            end
            bcpc_pkg::SP_HOLD_INSPI: plateau_cmd(p);
            bcpc_pkg::SP_EXHALE: begin
              blw      = bcpc_pkg::BL_CLOSE;
              pat      = bcpc_pkg::PV_OPEN;
              cap_peep = p;
            end
            default: begin
              blw = bcpc_pkg::BL_CLOSE;
              pat = bcpc_pkg::PV_CLOSE;
            end
          endcase
        end
        // peak safeguard
        if (sub == bcpc_pkg::SP_INSPI) begin
          if (pv >= pk - bcpc_pkg::PEAK_TRIG_MARGIN) begin
            arm(PK_TRIG, now);
            if (since(PK_TRIG, now) >= int'(bcpc_pkg::PEAK_DEBOUNCE)) begin
              blw = bcpc_pkg::BL_MIDDLE;
              vig = 1;
            end
          end else if (armed[PK_TRIG]) begin
            arm(PK_REL, now);
            if (since(PK_REL, now) >= int'(bcpc_pkg::RELEASE_DEBOUNCE)) begin
              clear(PK_TRIG);
              clear(PK_REL);
            end
          end
          if (pv >= pk) begin
            set_sub(bcpc_pkg::SP_HOLD_INSPI);
            yellow = 1;
            plateau_cmd(p);
          end
        end
        if (pv >= pk + bcpc_pkg::PEAK_HIGH_MARGIN) begin
          p_inc  = 1;
          yellow = 1;
        end
        // plateau safeguard
        if (sub == bcpc_pkg::SP_HOLD_INSPI) begin
          if (pv >= pl) begin
            arm(PL_TRIG, now);
          end else if (armed[PL_TRIG]) begin
            arm(PL_REL, now);
            if (since(PL_REL, now) >= int'(bcpc_pkg::RELEASE_DEBOUNCE)) begin
              clear(PL_TRIG);
              clear(PL_REL);
              plateau_cmd(p);
            end
          end
        end
        // expiratory hold
        if (ph == bcpc_pkg::PH_EXHALE) begin
          if (pv <= pp + bcpc_pkg::PEEP_HOLD_MARGIN) begin
            arm(HD_TRIG, now);
            if (since(HD_TRIG, now) >= int'(bcpc_pkg::HOLD_DEBOUNCE)) begin
              set_sub(bcpc_pkg::SP_HOLD_EXHALE);
              blw = bcpc_pkg::BL_CLOSE;
              pat = bcpc_pkg::PV_CLOSE;
            end
          end else if (armed[HD_TRIG]) begin
            arm(HD_REL, now);
            if (since(HD_REL, now) >= int'(bcpc_pkg::RELEASE_DEBOUNCE)) begin
              clear(HD_TRIG);
              clear(HD_REL);
            end
          end
        end
        if (pv <= pp) begin
          b_inc = 1;
          red   = 1;
        end
      end
      r.ph     = ph;
      r.sub    = sub;
      r.blw    = blw;
      r.b_inc  = b_inc;
      r.pat    = pat;
      r.p_inc  = p_inc;
      r.yellow = yellow;
      r.red    = red;
      r.peak_v = cap_peak;
      r.plat_v = cap_plat;
      r.peep_v = cap_peep;
      r.vig    = vig;
      expected_words.push_back(r);
    endfunction

    function void cmp(string name, int e, int a);
      if (e != a) begin
        errors++;
        if (errors <= 10) $display("mismatch %s: expected %0d, got %0d", name, e, a);
      end
    endfunction

    function void check_word(logic [OUT_W-1:0] w);
      result_t a;
      result_t e;
      a = result_t'(w);
      if (expected_words.size() == 0) begin
        errors++;
        if (errors <= 10) $display("result word %h with nothing expected", w);
        return;
      end
      e = expected_words.pop_front();
      cmp("cycle_phase", e.ph, a.ph);
      cmp("sub_phase", e.sub, a.sub);
      cmp("blower_action", e.blw, a.blw);
      cmp("blower_increase", e.b_inc, a.b_inc);
      cmp("patient_action", e.pat, a.pat);
      cmp("patient_increase", e.p_inc, a.p_inc);
      cmp("yellow_alarm", e.yellow, a.yellow);
      cmp("red_alarm", e.red, a.red);
      cmp("peak_value", e.peak_v, a.peak_v);
      cmp("plateau_value", e.plat_v, a.plat_v);
      cmp("peep_value", e.peep_v, a.peep_v);
      cmp("vigilance_on", e.vig, a.vig);
    endfunction

    function int pending();
      return expected_words.size();
    endfunction
  endclass

  logic                           clk_i;
  logic                           rst_ni;
  // tdata: pressure[11:0], centisec[25:12], zero pad
  logic [IN_W-1:0]                s_axis_tdata;
  // tuser: req_type (start of cycle)
  logic                           s_axis_tuser;
  logic                           s_axis_tvalid;
  logic                           s_axis_tready;
  // tdata: cycle_phase, sub_phase, blower_action, blower_increase, patient_action,
  //        patient_increase, yellow_alarm, red_alarm, peak, plateau, peep, vigilance
  logic [OUT_W-1:0]               m_axis_tdata;
  logic                           m_axis_tvalid;
  logic                           m_axis_tready;
  logic                           cfg_we_i;
  logic [bcpc_pkg::CFG_IDX_W-1:0] cfg_idx_i;
  logic [bcpc_pkg::CFG_W-1:0]     cfg_data_i;

  breath_tracker sb;
  int            send_idle_pct;
  int            recv_stall_pct;
  bit            hold_req;
  int            hold_left;
  int            words_sent;

  breath_cycle_phase_controller u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Run limit; a hang ends here.
  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("[FAIL] regression broken");
    $finish;
  end

  // Result side: check each taken word, then pick tready for the next edge.
  // A requested hold-off is counted down here while the sender keeps pushing.
  initial begin : result_side
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_word(m_axis_tdata);
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (hold_req) begin
        hold_req  = 0;
        hold_left = HOLD_OFF;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  function automatic int spread(int lo, int hi);
    return lo + int'($urandom_range(hi - lo));
  endfunction

  function automatic logic signed [PB-1:0] to_p(int v);
    if (v > 2047) v = 2047;
    if (v < -2048) v = -2048;
    return PB'(v);
  endfunction

  // Offer one word; tvalid stays up after the handshake so back-to-back words
  // need no extra edge. The word is noted at the edge that takes it.
  task automatic send_word(bit start, int p, int cs);
    logic signed [PB-1:0] pw;
    logic [TB-1:0]        cw;
    pw = to_p(p);
    cw = TB'(cs);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= start;
    s_axis_tdata  <= IN_W'({cw, pw});
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_word(start, pw, cw);
    words_sent++;
  endtask

  // Stop offering and wait for every expected word, then let the block settle.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic put_reg(bcpc_pkg::cfg_idx_e idx, int v);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= bcpc_pkg::CFG_W'(v);
    @(posedge clk_i);
    sb.set_reg(idx, bcpc_pkg::CFG_W'(v));
  endtask

  task automatic write_regs(int rate, int peep, int plat, int peak);
    put_reg(bcpc_pkg::CFG_RATE, rate);
    put_reg(bcpc_pkg::CFG_PEEP, peep);
    put_reg(bcpc_pkg::CFG_PLAT, plat);
    put_reg(bcpc_pkg::CFG_PEAK, peak);
    cfg_we_i <= 1'b0;
  endtask

  // One well-formed breath: start, ramp to a peak near the limit, plateau,
  // then decay to around PEEP, with the odd wild pressure thrown in.
  // Ticks stop early once the word count reaches the target.
  task automatic breath(int target);
    int cyc;
    int thr;
    int step_max;
    int top;
    int plat_l;
    int peep_l;
    int stop_at;
    int cs;
    int pv;
    send_word(1, spread(-2048, 2047), spread(0, 16383));
    cyc      = int'(sb.inh) * 3;
    thr      = int'(sb.inh) * 80 / 100;
    step_max = (cyc / 25 > 1) ? cyc / 25 : 1;
    top      = int'(sb.peak_cfg) + spread(-60, 20);
    plat_l   = int'(sb.plat_cfg) + spread(-40, 40);
    peep_l   = int'(sb.peep_cfg) + spread(-20, 40);
    stop_at  = cyc + spread(0, cyc / 4);
    if (stop_at > 16383) stop_at = 16383;
    cs = spread(0, 2);
    while (cs <= stop_at && words_sent < target) begin
      if (cs * 5 < thr * 3)
        pv = peep_l + (top - peep_l) * cs * 5 / (thr * 3) + spread(-15, 15);
      else if (cs < thr)
        pv = top + spread(-15, 15);
      else if (cs < int'(sb.inh))
        pv = plat_l + spread(-30, 30);
      else
        pv = peep_l + spread(-25, 25);
      if ($urandom_range(99) < 4) pv = spread(-2048, 2047);
      send_word(0, pv, cs);
      cs += spread(1, step_max);
    end
  endtask

  task automatic run_breaths(int quota);
    int target;
    target = words_sent + quota;
    while (words_sent < target) begin
      if ($urandom_range(99) < 8)
        send_word($urandom_range(3) == 0, spread(-2048, 2047), spread(0, 16383));
      else
        breath(target);
    end
  endtask

  initial begin : stimulus
    rst_ni         = 1'b0;
    s_axis_tvalid  = 1'b0;
    s_axis_tuser   = 1'b0;
    s_axis_tdata   = '0;
    m_axis_tready  = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = bcpc_pkg::CFG_RATE;
    cfg_data_i     = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_req       = 0;
    hold_left      = 0;
    words_sent     = 0;
    sb             = new();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed, reset settings (rate 20: inhale 100, hold from 80).
    send_word(0, 0, 0);           // red alarm
    send_word(0, 2047, 16383);    // exhale, peak exceeded
    send_word(0, -2048, 0);
    send_word(1, 0, 0);
    send_word(0, 580, 0);         // peak trigger armed
    send_word(0, 590, 3);
    send_word(0, 575, 5);         // debounced: vigilance, blower middle
    send_word(0, 560, 6);         // release armed
    send_word(0, 560, 9);         // peak trigger released
    send_word(0, 600, 12);        // peak reached: forced plateau, yellow
    send_word(0, 615, 14);        // over peak by margin, plateau armed
    send_word(0, 250, 20);
    send_word(0, 240, 23);        // plateau release
    send_word(0, 320, 85);        // hold by time
    send_word(0, 90, 100);        // exhale
    send_word(0, 65, 110);        // expiratory hold armed
    send_word(0, 60, 120);        // expiratory hold
    send_word(0, 45, 125);
    send_word(0, 200, 130);
    send_word(0, 200, 140);       // hold trigger released
    send_word(1, -1, 16383);
    send_word(0, 2047, 0);        // stale peak stamps from the last cycle
    send_word(0, -1, 16383);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: write_regs(0, 0, 0, 0);          // zero rate, all limits at floor
        1: write_regs(63, 511, 1023, 1023);
        2: write_regs(20, 50, 300, 600);
        default: begin
          int plat;
          plat = spread(150, 600);
          write_regs(spread(5, 35), spread(0, 150), plat, spread(plat + 50, 1000));
        end
      endcase
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 51; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 51; end
        default: begin send_idle_pct = 26; recv_stall_pct = 26; end
      endcase
      run_breaths(115);
      if (ph % 4 == 2) hold_req = 1;   // long output stall, input keeps coming
      if (ph % 4 == 3) drain();        // sender pause until all results are back
      run_breaths(115);
      drain();
    end

    if (sb.errors == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
